/* hw/rtl/gf3hw_pkg.sv */
package gf3hw_pkg;

    localparam int NUM_ELEM  = 8;
    localparam int VEC_W     = 64;

    // One trit: y flag means 2, x flag means 1.
    typedef struct packed {
        logic y;
        logic x;
    } t_trit;

    typedef t_trit [NUM_ELEM-1:0] t_trit_vec;

    function automatic t_trit tadd(input t_trit f, input t_trit g);
        logic  sx;
        logic  sy;
        logic  o;
        t_trit r;
        sx  = (f.x ^ g.x) ^ (f.y & g.y);
        sy  = f.y ^ g.y ^ (f.x & g.x);
        o   = sx & sy;
        r.x = sx ^ o;
        r.y = sy ^ o;
        return r;
    endfunction

    function automatic t_trit tneg(input t_trit f);
        t_trit r;
        r.x = f.y;
        r.y = f.x;
        return r;
    endfunction

    function automatic t_trit tsub(input t_trit f, input t_trit g);
        return tadd(f, tneg(g));
    endfunction

endpackage

/* hw/rtl/gf3hw_lane.sv */
module gf3hw_lane (
    input  logic                i_invert,
    input  gf3hw_pkg::t_trit_vec i_vec,
    output gf3hw_pkg::t_trit_vec o_coef
);
    import gf3hw_pkg::*;

    t_trit_vec fwd;
    t_trit_vec inv;
    t_trit     p [4];
    t_trit     pp [2];
    t_trit     q [4];
    t_trit     qq [2];

    // Forward: three butterfly levels, differences kept, sums passed on.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            p[i]       = tadd(i_vec[2*i], i_vec[2*i+1]);
            fwd[4 + i] = tsub(i_vec[2*i], i_vec[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            pp[i]      = tadd(p[2*i], p[2*i+1]);
            fwd[2 + i] = tsub(p[2*i], p[2*i+1]);
        end
        fwd[0] = tadd(pp[0], pp[1]);
        fwd[1] = tsub(pp[0], pp[1]);
    end

    // Inverse: each pair is rebuilt from sum p and difference m as -(p+m), m-p.
    always_comb begin
        qq[0] = tneg(tadd(i_vec[0], i_vec[1]));
        qq[1] = tsub(i_vec[1], i_vec[0]);
        for (int i = 0; i < 2; i++) begin
            q[2*i]   = tneg(tadd(qq[i], i_vec[2+i]));
            q[2*i+1] = tsub(i_vec[2+i], qq[i]);
        end
        for (int i = 0; i < 4; i++) begin
            inv[2*i]   = tneg(tadd(q[i], i_vec[4+i]));
            inv[2*i+1] = tsub(i_vec[4+i], q[i]);
        end
    end

    assign o_coef = i_invert ? inv : fwd;

endmodule

/* hw/rtl/gf3hw_merge.sv */
module gf3hw_merge #(
    parameter int LANES = 32
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_valid,
    output logic                                                   o_ready,
    input  gf3hw_pkg::t_trit_vec [LANES-1:0]                       i_lane_coef,
    output logic                                                   o_valid,
    input  logic                                                   i_ready,
    output logic [gf3hw_pkg::NUM_ELEM-1:0][gf3hw_pkg::VEC_W-1:0]   o_coef
);
    import gf3hw_pkg::*;

    logic [NUM_ELEM-1:0][VEC_W-1:0] n_coef;
    logic [NUM_ELEM-1:0][VEC_W-1:0] r_coef;
    logic                           r_valid;

    // Gather each element's trit from every lane; bits above the lanes stay zero.
    always_comb begin
        n_coef = '0;
        for (int e = 0; e < NUM_ELEM; e++) begin
            for (int l = 0; l < LANES; l++) begin
                n_coef[e][2*l +: 2] = i_lane_coef[l][e];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_coef <= n_coef;
        end
    end

    assign o_valid = r_valid;
    assign o_coef  = r_coef;

endmodule

/* hw/rtl/gf3_haar_wavelet_8pt_core.sv */
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_invert, i_vec_0 .. i_vec_7
// result    out        o_valid / i_ready   o_coef_0 .. o_coef_7
//
// One item is taken every cycle unless a result is stalled, and its result
// appears in the next cycle, in the output register of the merge stage.
// Reset (synchronous, active low) clears only the output valid flag.
// When the result is stalled, a new item is still taken in the same cycle
// that the waiting result leaves, one per cycle as long as i_ready is high.
module gf3_haar_wavelet_8pt_core #(
    parameter int LANES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_invert,
    input  logic [63:0] i_vec_0,
    input  logic [63:0] i_vec_1,
    input  logic [63:0] i_vec_2,
    input  logic [63:0] i_vec_3,
    input  logic [63:0] i_vec_4,
    input  logic [63:0] i_vec_5,
    input  logic [63:0] i_vec_6,
    input  logic [63:0] i_vec_7,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_coef_0,
    output logic [63:0] o_coef_1,
    output logic [63:0] o_coef_2,
    output logic [63:0] o_coef_3,
    output logic [63:0] o_coef_4,
    output logic [63:0] o_coef_5,
    output logic [63:0] o_coef_6,
    output logic [63:0] o_coef_7
);
    import gf3hw_pkg::*;

    // Bits of each word that carry lanes; everything above reads as zero.
    localparam logic [VEC_W-1:0] LANE_MASK = {VEC_W{1'b1}} >> (VEC_W - 2 * LANES);

    logic [NUM_ELEM-1:0][VEC_W-1:0] in_vec;
    logic [NUM_ELEM-1:0][VEC_W-1:0] out_coef;
    t_trit_vec [LANES-1:0]          lane_in;
    t_trit_vec [LANES-1:0]          lane_out;

    assign in_vec = {i_vec_7, i_vec_6, i_vec_5, i_vec_4,
                     i_vec_3, i_vec_2, i_vec_1, i_vec_0};

    // Each lane is an independent GF(3) transform on one trit position of
    // all eight elements. The lanes are purely combinational, so the whole
    // transform settles in the cycle of the transfer.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_comb begin
            for (int e = 0; e < NUM_ELEM; e++) begin
                lane_in[l][e] = in_vec[e][2*l +: 2];
            end
        end

        gf3hw_lane u_lane (
            .i_invert (i_invert),
            .i_vec    (lane_in[l]),
            .o_coef   (lane_out[l])
        );
    end

    // The merge stage reassembles the lane results into words and registers
    // them; it also owns the handshake on both sides.
    gf3hw_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_lane_coef (lane_out),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_coef      (out_coef)
    );

    assign o_coef_0 = out_coef[0];
    assign o_coef_1 = out_coef[1];
    assign o_coef_2 = out_coef[2];
    assign o_coef_3 = out_coef[3];
    assign o_coef_4 = out_coef[4];
    assign o_coef_5 = out_coef[5];
    assign o_coef_6 = out_coef[6];
    assign o_coef_7 = out_coef[7];

    // A transfer on the input always produces a pending result next cycle.
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("input transfer did not produce a result");

    // A stalled result is never dropped.
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("stalled result was lost");

    // Bits above the lanes are zero on coefficient words 0 and 7 of every pending result.
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_coef_0 & ~LANE_MASK) == '0) && ((o_coef_7 & ~LANE_MASK) == '0))
        else $error("result bits above the lanes are not zero");

    // A forward transfer of all-zero elements yields a zero total sum.
    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_invert && (i_vec_0 == '0) && (i_vec_1 == '0)
        && (i_vec_2 == '0) && (i_vec_3 == '0) && (i_vec_4 == '0) && (i_vec_5 == '0)
        && (i_vec_6 == '0) && (i_vec_7 == '0) |=> (o_coef_0 == '0))
        else $error("zero input gave a nonzero total sum");

endmodule

/* tb/gf3_haar_wavelet_8pt_core_tb.sv */
module gf3_haar_wavelet_8pt_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The lane count is a parameter of the core, so the predictor works from
    // the same value and masks everything above the active lanes.
    localparam int LANES = 32;
    localparam int NE    = gf3hw_pkg::NUM_ELEM;
    localparam int VW    = gf3hw_pkg::VEC_W;

    localparam logic [VW-1:0] X_PLANE = 64'h5555_5555_5555_5555;
    localparam logic [VW-1:0] Y_PLANE = 64'hAAAA_AAAA_AAAA_AAAA;

    // Eight 64-bit trit words travel together, both on the way in and out.
    typedef logic [NE-1:0][VW-1:0] t_word_set;

    // The number of random transfers and how they are split into phases.
    localparam int RANDOM_ITEMS = 1880;
    localparam int PHASES       = 8;

    // Every result that the core owes is kept here in order. The class also
    // holds its own GF(3) arithmetic, done on whole bit planes at once.
    class haar_checker;
        typedef struct packed {
            logic [VW-1:0] y;
            logic [VW-1:0] x;
        } t_plane;

        t_word_set expected_coefs[$];
        int        mismatches;
        int        checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function logic [VW-1:0] lane_mask();
            if (LANES >= 32) begin
                return '1;
            end
            return (64'd1 << (2 * LANES)) - 64'd1;
        endfunction

        function t_plane split(input logic [VW-1:0] w);
            t_plane p;
            logic [VW-1:0] m;
            m   = w & lane_mask();
            p.x = m & X_PLANE;
            p.y = (m >> 1) & X_PLANE;
            return p;
        endfunction

        function logic [VW-1:0] join_planes(input t_plane p);
            return ((p.x & X_PLANE) | ((p.y & X_PLANE) << 1)) & lane_mask();
        endfunction

        // Lane-wise sum; pattern 11 lanes simply follow the same formula.
        function t_plane gf_sum(input t_plane f, input t_plane g);
            t_plane r;
            logic [VW-1:0] sx;
            logic [VW-1:0] sy;
            logic [VW-1:0] both;
            sx   = (f.x ^ g.x) ^ (f.y & g.y);
            sy   = f.y ^ g.y ^ (f.x & g.x);
            both = sx & sy;
            r.x  = sx ^ both;
            r.y  = sy ^ both;
            return r;
        endfunction

        function t_plane gf_negate(input t_plane f);
            t_plane r;
            r.x = f.y;
            r.y = f.x;
            return r;
        endfunction

        function t_plane gf_diff(input t_plane f, input t_plane g);
            return gf_sum(f, gf_negate(g));
        endfunction

        // Rebuilds a pair from its sum p and difference m.
        function void rebuild_pair(input t_plane p, input t_plane m,
                                   output t_plane lo, output t_plane hi);
            lo = gf_negate(gf_sum(p, m));
            hi = gf_diff(m, p);
        endfunction

        function t_word_set haar_transform(input logic inverse, input t_word_set vin);
            t_plane    v[NE];
            t_plane    r[NE];
            t_plane    p[4];
            t_plane    pp[2];
            t_word_set coefs;
            for (int i = 0; i < NE; i++) begin
                v[i] = split(vin[i]);
            end
            if (!inverse) begin
                for (int i = 0; i < 4; i++) begin
                    p[i]     = gf_sum(v[2*i], v[2*i+1]);
                    r[4 + i] = gf_diff(v[2*i], v[2*i+1]);
                end
                for (int i = 0; i < 2; i++) begin
                    pp[i]    = gf_sum(p[2*i], p[2*i+1]);
                    r[2 + i] = gf_diff(p[2*i], p[2*i+1]);
                end
                r[0] = gf_sum(pp[0], pp[1]);
                r[1] = gf_diff(pp[0], pp[1]);
            end else begin
                rebuild_pair(v[0], v[1], pp[0], pp[1]);
                for (int i = 0; i < 2; i++) begin
                    rebuild_pair(pp[i], v[2+i], p[2*i], p[2*i+1]);
                end
                for (int i = 0; i < 4; i++) begin
                    rebuild_pair(p[i], v[4+i], r[2*i], r[2*i+1]);
                end
            end
            for (int i = 0; i < NE; i++) begin
                coefs[i] = join_planes(r[i]);
            end
            return coefs;
        endfunction

        function void note_block(input logic inverse, input t_word_set vin);
            expected_coefs.push_back(haar_transform(inverse, vin));
        endfunction

        function void check_coefs(input t_word_set got);
            t_word_set want;
            if (expected_coefs.size() == 0) begin
                mismatches++;
                $display("%0t: result arrived with nothing outstanding, coef_0=%h",
                         $time, got[0]);
                return;
            end
            want = expected_coefs.pop_front();
            checked++;
            for (int i = 0; i < NE; i++) begin
                if (got[i] !== want[i]) begin
                    mismatches++;
                    $display("%0t: coef_%0d expected %h actual %h",
                             $time, i, want[i], got[i]);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_invert;
    logic [63:0] i_vec_0, i_vec_1, i_vec_2, i_vec_3;
    logic [63:0] i_vec_4, i_vec_5, i_vec_6, i_vec_7;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_coef_0, o_coef_1, o_coef_2, o_coef_3;
    logic [63:0] o_coef_4, o_coef_5, o_coef_6, o_coef_7;

    gf3_haar_wavelet_8pt_core #(
        .LANES(LANES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_invert(i_invert),
        .i_vec_0 (i_vec_0),
        .i_vec_1 (i_vec_1),
        .i_vec_2 (i_vec_2),
        .i_vec_3 (i_vec_3),
        .i_vec_4 (i_vec_4),
        .i_vec_5 (i_vec_5),
        .i_vec_6 (i_vec_6),
        .i_vec_7 (i_vec_7),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_coef_0(o_coef_0),
        .o_coef_1(o_coef_1),
        .o_coef_2(o_coef_2),
        .o_coef_3(o_coef_3),
        .o_coef_4(o_coef_4),
        .o_coef_5(o_coef_5),
        .o_coef_6(o_coef_6),
        .o_coef_7(o_coef_7)
    );

    haar_checker board = new();

    // Both the sender and the receiver insert idle bursts only while this
    // flag is set; the stimulus process flips it per phase.
    bit idle_on;
    int fwd_count;
    int inv_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Worst case is far below this: about 2000 transfers, each with at most one
    // idle gap and one stall, at 8 ns per cycle.
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", board.expected_coefs.size());
        $display("gf3_haar_wavelet_8pt_core: mismatch");
        $finish;
    end

    // Result side. Outputs are sampled right after the rising edge, so the
    // values seen are the ones present at that edge, before any update.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                board.check_coefs({o_coef_7, o_coef_6, o_coef_5, o_coef_4,
                                   o_coef_3, o_coef_2, o_coef_1, o_coef_0});
            end
            // Exactly one assignment to i_ready per edge.
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Presents one block and holds it until the core takes it. The task is
    // entered right after a rising edge, and it returns right after the edge
    // at which the transfer happened, so valid is never lowered and raised in
    // the same step.
    task automatic send_block(input logic inverse, input t_word_set v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_invert <= inverse;
        i_vec_0  <= v[0];
        i_vec_1  <= v[1];
        i_vec_2  <= v[2];
        i_vec_3  <= v[3];
        i_vec_4  <= v[4];
        i_vec_5  <= v[5];
        i_vec_6  <= v[6];
        i_vec_7  <= v[7];
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        board.note_block(inverse, v);
        if (inverse) begin
            inv_count++;
        end else begin
            fwd_count++;
        end
    endtask

    // One word of well-formed trits, each lane drawn from 0, 1 and 2.
    function automatic logic [63:0] clean_trits();
        logic [63:0] w;
        w = '0;
        for (int lane = 0; lane < 32; lane++) begin
            case ($urandom_range(0, 2))
                1: begin
                    w[2*lane] = 1'b1;
                end
                2: begin
                    w[2*lane+1] = 1'b1;
                end
                default: begin
                end
            endcase
        end
        return w;
    endfunction

    // Mostly clean trit words, with raw bit patterns (which bring in the
    // invalid 11 lane pattern) and a few uniform or sparse words mixed in.
    function automatic logic [63:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return clean_trits();
        end else if (pick < 9) begin
            return {$urandom(), $urandom()};
        end
        case ($urandom_range(0, 3))
            0: begin
                return X_PLANE;
            end
            1: begin
                return Y_PLANE;
            end
            2: begin
                return 64'd1 << $urandom_range(0, 63);
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    initial begin
        t_word_set v;
        int        wait_cycles;
        int        per_phase;

        idle_on   = 1'b0;
        fwd_count = 0;
        inv_count = 0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_invert <= 1'b0;
        i_vec_0  <= '0;
        i_vec_1  <= '0;
        i_vec_2  <= '0;
        i_vec_3  <= '0;
        i_vec_4  <= '0;
        i_vec_5  <= '0;
        i_vec_6  <= '0;
        i_vec_7  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks, each in both directions: all zero, every lane in
        // the invalid 11 pattern, every lane 1, every lane 2, alternating 1
        // and 2 across elements, a single lone flag per element that walks
        // across the lanes, the lowest and highest bits, and one top-lane 11.
        for (int dir = 0; dir < 2; dir++) begin
            send_block(dir[0], '0);
            send_block(dir[0], '1);
            for (int i = 0; i < NE; i++) v[i] = X_PLANE;
            send_block(dir[0], v);
            for (int i = 0; i < NE; i++) v[i] = Y_PLANE;
            send_block(dir[0], v);
            for (int i = 0; i < NE; i++) v[i] = i[0] ? Y_PLANE : X_PLANE;
            send_block(dir[0], v);
            for (int i = 0; i < NE; i++) v[i] = 64'd1 << (9 * i);
            send_block(dir[0], v);
            for (int i = 0; i < NE; i++) v[i] = 64'h8000_0000_0000_0001;
            send_block(dir[0], v);
            for (int i = 0; i < NE; i++) v[i] = (i == 3) ? 64'hC000_0000_0000_0000 : '0;
            send_block(dir[0], v);
        end

        // Random blocks. Idling is switched on in alternate phases and is off
        // in the last one, so the core is also run at full rate back to back.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph % 2 == 0) && (ph != PHASES - 1);
            for (int n = 0; n < per_phase; n++) begin
                for (int i = 0; i < NE; i++) v[i] = random_word();
                send_block(1'($urandom_range(0, 1)), v);
            end
        end
        idle_on = 1'b0;
        i_valid <= 1'b0;

        // Drain, then keep clocking the output register in case an unexpected
        // result shows up late.
        wait_cycles = 0;
        while (board.expected_coefs.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (board.expected_coefs.size() != 0) begin
            board.mismatches += board.expected_coefs.size();
            $display("%0t: %0d results never arrived", $time,
                     board.expected_coefs.size());
        end

        $display("Ran %0d forward and %0d inverse blocks of %0d lanes, %0d results compared.",
                 fwd_count, inv_count, LANES, board.checked);
        $display("Stimulus mixed clean trits, raw bit patterns and uniform words, %0d errors.",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("gf3_haar_wavelet_8pt_core: match");
        end else begin
            $display("gf3_haar_wavelet_8pt_core: mismatch");
        end
        $finish;
    end

endmodule
